[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked while out of reset.
`define ZBU_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define ZBU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/zbu_pkg.sv]
package zbu_pkg;

  localparam int unsigned DEF_HEADER_BYTES = 4;
  localparam int unsigned DEF_GROUP_BYTES  = 8;

  // Original length and output position are kept to 32 bits
  localparam int unsigned LEN_W  = 32;
  localparam int unsigned BYTE_W = 8;

  typedef struct packed {
    logic clear;    // new stream: length and position back to zero
    logic shift;    // header byte: shift into length
    logic advance;  // one byte emitted
  } len_ctl_t;

  typedef struct packed {
    logic fin;       // current position is the last of the original length
    logic len_zero;  // length after this header byte would be zero
  } len_stat_t;

endpackage

[hw/rtl/zbu_len_unit.sv]
module zbu_len_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  zbu_pkg::len_ctl_t           ctl_i,
  input  logic [zbu_pkg::BYTE_W-1:0]  byte_i,
  output zbu_pkg::len_stat_t          stat_o
);

  logic [zbu_pkg::LEN_W-1:0] len_q, len_d;
  logic [zbu_pkg::LEN_W-1:0] pos_q, pos_d;
  logic [zbu_pkg::LEN_W-1:0] len_base;
  logic [zbu_pkg::LEN_W-1:0] len_shift;

  always_comb begin
    len_base  = ctl_i.clear ? '0 : len_q;
    // Only the low bits survive a header longer than the length register
    len_shift = {len_base[zbu_pkg::LEN_W-zbu_pkg::BYTE_W-1:0], byte_i};

    len_d = len_q;
    if (ctl_i.clear) begin
      len_d = '0;
    end
    if (ctl_i.shift) begin
      len_d = len_shift;
    end

    pos_d = pos_q;
    if (ctl_i.clear) begin
      pos_d = '0;
    end else if (ctl_i.advance) begin
      pos_d = pos_q + zbu_pkg::LEN_W'(1);
    end

    stat_o.fin      = (pos_q + zbu_pkg::LEN_W'(1)) == len_q;
    stat_o.len_zero = len_shift == '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      pos_q <= '0;
    end else begin
      len_q <= len_d;
      pos_q <= pos_d;
    end
  end

endmodule

[hw/rtl/zero_bitmask_unpacker.sv]
// Header bytes: no results.
// Tag or literal item with n results: accepted, then one result per cycle from the
// shared emit step while the output is not stalled; acceptance moves it to the emit
// state, from which each result is registered, and input waits for its last result.
// Items without results (header, all-literal lead, excess) never hold off the input.
// Reset (async, active low) returns to the header phase with length and position zero.
module zero_bitmask_unpacker #(
  parameter int unsigned HEADER_BYTES = zbu_pkg::DEF_HEADER_BYTES,
  parameter int unsigned GROUP_BYTES  = zbu_pkg::DEF_GROUP_BYTES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tuser_i,   // [0] stream_start
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tuser_o,   // [0] out_final
  output logic       m_axis_tlast_o    // run_last
);

  localparam int unsigned HC_W = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
  localparam int unsigned BI_W = $clog2(GROUP_BYTES + 1);

  typedef enum logic [1:0] {PH_HEADER, PH_TAG, PH_LITERAL, PH_DONE} phase_e;
  typedef enum logic {ST_IDLE, ST_EMIT} state_e;

  state_e                     state_q, state_d;
  phase_e                     phase_q, phase_d;
  phase_e                     ph_eff;
  logic [HC_W-1:0]            hc_q, hc_d, hc_eff;
  logic [GROUP_BYTES-1:0]     mask_q, mask_d, mask_sh;
  logic [BI_W-1:0]            bi_q, bi_d, bi_nxt;
  logic                       lit_q, lit_d;
  logic [zbu_pkg::BYTE_W-1:0] byte_q, byte_d;
  logic                       m_valid_q, m_valid_d;
  logic [zbu_pkg::BYTE_W-1:0] m_data_q, m_data_d;
  logic                       m_final_q, m_final_d;
  logic                       m_last_q, m_last_d;
  logic                       acc, step, run_end, grp_end;
  zbu_pkg::len_ctl_t          len_ctl;
  zbu_pkg::len_stat_t         len_stat;

  zbu_len_unit u_len (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (len_ctl),
    .byte_i (s_axis_tdata_i),
    .stat_o (len_stat)
  );

  always_comb begin
    acc    = s_axis_tvalid_i && (state_q == ST_IDLE);
    ph_eff = s_axis_tuser_i ? PH_HEADER : phase_q;
    hc_eff = s_axis_tuser_i ? '0 : hc_q;
    step   = (state_q == ST_EMIT) && (!m_valid_q || m_axis_tready_i);

    bi_nxt  = bi_q + BI_W'(1);
    mask_sh = GROUP_BYTES'(mask_q >> bi_nxt);
    grp_end = bi_nxt == BI_W'(GROUP_BYTES);
    // Run stops at the final byte, the group's end or the next literal slot
    run_end = len_stat.fin || grp_end || mask_sh[0];

    len_ctl.clear   = acc && s_axis_tuser_i;
    len_ctl.shift   = acc && (ph_eff == PH_HEADER);
    len_ctl.advance = step;

    state_d   = state_q;
    phase_d   = phase_q;
    hc_d      = hc_q;
    mask_d    = mask_q;
    bi_d      = bi_q;
    lit_d     = lit_q;
    byte_d    = byte_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_final_d = m_final_q;
    m_last_d  = m_last_q;

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    if (acc) begin
      phase_d = ph_eff;
      hc_d    = hc_eff;
      if (s_axis_tuser_i) begin
        mask_d = '0;
        bi_d   = '0;
      end
      unique case (ph_eff)
        PH_HEADER: begin
          if (hc_eff == HC_W'(HEADER_BYTES - 1)) begin
            hc_d    = '0;
            phase_d = len_stat.len_zero ? PH_DONE : PH_TAG;
          end else begin
            hc_d = hc_eff + HC_W'(1);
          end
        end
        PH_TAG: begin
          mask_d = s_axis_tdata_i[GROUP_BYTES-1:0];
          bi_d   = '0;
          if (s_axis_tdata_i[0]) begin
            phase_d = PH_LITERAL;
          end else begin
            lit_d   = 1'b0;
            state_d = ST_EMIT;
          end
        end
        PH_LITERAL: begin
          lit_d   = 1'b1;
          byte_d  = s_axis_tdata_i;
          state_d = ST_EMIT;
        end
        default: begin
          phase_d = ph_eff;
        end
      endcase
    end

    if (step) begin
      m_valid_d = 1'b1;
      m_data_d  = lit_q ? byte_q : '0;
      m_final_d = len_stat.fin;
      m_last_d  = run_end;
      bi_d      = bi_nxt;
      lit_d     = 1'b0;
      if (run_end) begin
        state_d = ST_IDLE;
        if (len_stat.fin) begin
          phase_d = PH_DONE;
        end else if (grp_end) begin
          phase_d = PH_TAG;
        end else begin
          phase_d = PH_LITERAL;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= PH_HEADER;
      hc_q      <= '0;
      mask_q    <= '0;
      bi_q      <= '0;
      lit_q     <= 1'b0;
      byte_q    <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_final_q <= 1'b0;
      m_last_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      hc_q      <= hc_d;
      mask_q    <= mask_d;
      bi_q      <= bi_d;
      lit_q     <= lit_d;
      byte_q    <= byte_d;
      m_valid_q <= m_valid_d;
      m_data_q  <= m_data_d;
      m_final_q <= m_final_d;
      m_last_q  <= m_last_d;
    end
  end

  assign s_axis_tready_o = state_q == ST_IDLE;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_final_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule

[hw/rtl/zbu_checker.sv]
`include "assert_macros.svh"

module zbu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tuser_o,
  input logic       m_axis_tlast_o
);

  // A stalled item keeps its payload
  `ZBU_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o), "output item changed while stalled")

  // Final byte of the stream always closes its run
  `ZBU_ASSERT(a_final_last, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o, "final byte without run end")

  // Mid-run: no new input taken
  `ZBU_ASSERT(a_run_busy, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |-> !s_axis_tready_o, "input taken during a run")

  `ZBU_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |-> !m_axis_tvalid_o, "output valid in reset")

endmodule

bind zero_bitmask_unpacker zbu_checker u_zbu_checker (.*);
